// ----- design/positional_list_insert_delete_macros.svh -----
// Assertion macros shared by the checker of the positional list.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// Checked at every rising edge outside reset.
`define PLI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PLI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/pli_pkg.sv -----
`default_nettype none

package pli_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned POS_W = 7;
	localparam int unsigned LEN_W = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		logic              ins;
		logic              del;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- design/positional_list_insert_delete.sv -----
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values, one operation per transaction.
// Input channel: start with operation, position and new_value; a transaction is taken
// at a rising edge where start is high and busy is low. busy stays low, so a new
// transaction may be issued in every cycle.
// Result channel: done is high for exactly one cycle, the cycle after the transaction
// was taken, with status, read_value and length. The receiver cannot stall; every
// result must be taken in the cycle it is shown.
// Throughput is one operation per cycle. Every list slot is a cell holding one
// entry; on insert the cell at the position loads new_value and the cells above it
// load from their lower neighbour; on delete the cells at and above the position
// load from their upper neighbour, all in the same clock edge. A read picks the cell
// at the position. Reset zeroes every cell and count_q, with no clearing pass.
module positional_list_insert_delete
	import pli_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               operation,
	input  wire logic [POS_W-1:0]         position,
	input  wire logic signed [DATA_W-1:0] new_value,
	output logic                          done,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      read_value,
	output logic [LEN_W-1:0]              length
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              done_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] read_value_q;
	logic [LEN_W-1:0]  length_q;

	logic [DATA_W-1:0] ent [CAPACITY];
	logic [DATA_W-1:0] sel [CAPACITY];
	logic [DATA_W-1:0] sel_any;
	cell_cmd_t         cmd;

	logic [CMP_W-1:0]  pos_w;
	logic [CMP_W-1:0]  cnt_w;
	logic              accept;
	logic              ins_pos_ok;
	logic              in_range;
	logic              full;
	status_t           status_d;
	logic [DATA_W-1:0] read_d;

	assign accept     = start && !busy;
	assign busy       = 1'b0;
	assign pos_w      = CMP_W'(position);
	assign cnt_w      = CMP_W'(count_q);
	assign ins_pos_ok = (position != '0) && (pos_w <= cnt_w + CMP_W'(1));
	assign in_range   = (position != '0) && (pos_w <= cnt_w);
	assign full       = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		sel_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_any = sel_any | sel[i];
		end
	end

	always_comb begin
		cmd.ins   = 1'b0;
		cmd.del   = 1'b0;
		cmd.pos   = position;
		cmd.value = new_value;
		status_d  = ST_BADPOS;
		read_d    = '0;
		count_d   = count_q;
		unique case (op_t'(operation))
			OP_INSERT: begin
				if (!ins_pos_ok) begin
					status_d = ST_BADPOS;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_OK;
					cmd.ins  = accept;
					count_d  = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (in_range) begin
					status_d = ST_OK;
					cmd.del  = accept;
					count_d  = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (in_range) begin
					status_d = ST_OK;
					read_d   = sel_any;
				end
			end
			default: begin
				status_d = ST_BADPOS;
			end
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] lower;
		logic [DATA_W-1:0] upper;

		if (g == 0) begin : g_first
			assign lower = '0;
		end else begin : g_mid_lo
			assign lower = ent[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid_hi
			assign upper = ent[g+1];
		end

		pli_cell #(
			.IDX (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.lower_in  (lower),
			.upper_in  (upper),
			.value     (ent[g]),
			.sel_value (sel[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_d;
			read_value_q <= read_d;
			length_q     <= LEN_W'(count_d);
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign length     = length_q;

endmodule

`default_nettype wire

// ----- design/pli_cell.sv -----
`default_nettype none

module pli_cell
	import pli_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_cmd_t         cmd,
	input  wire logic [DATA_W-1:0] lower_in,
	input  wire logic [DATA_W-1:0] upper_in,
	output logic      [DATA_W-1:0] value,
	output logic      [DATA_W-1:0] sel_value
);

	localparam logic [31:0] SLOT = 32'(IDX + 1);

	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] value_d;
	logic              at_pos;
	logic              below_pos;
	logic [31:0]       pos_w;

	assign pos_w     = 32'(cmd.pos);
	assign at_pos    = (pos_w == SLOT);
	assign below_pos = (pos_w < SLOT);

	always_comb begin
		value_d = value_q;
		if (cmd.ins) begin
			if (at_pos) begin
				value_d = cmd.value;
			end else if (below_pos) begin
				value_d = lower_in;
			end
		end else if (cmd.del) begin
			if (at_pos || below_pos) begin
				value_d = upper_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else begin
			value_q <= value_d;
		end
	end

	assign value     = value_q;
	assign sel_value = at_pos ? value_q : '0;

endmodule

`default_nettype wire

// ----- design/pli_checker.sv -----
`default_nettype none

`include "positional_list_insert_delete_macros.svh"

module pli_checker
	import pli_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic [POS_W-1:0]         position,
	input wire logic                     done,
	input wire logic [1:0]               status,
	input wire logic signed [DATA_W-1:0] read_value
);

	`PLI_ASSERT(a_done_follows_start, start && !busy |=> done, "accepted transaction gave no result")
	`PLI_ASSERT(a_no_spurious_done, !(start && !busy) |=> !done, "result without a transaction")
	`PLI_ASSERT(a_reject_reads_zero, done && status != ST_OK |-> read_value == '0, "rejected transaction returned data")
	`PLI_ASSERT(a_full_needs_position, done && status == ST_FULL |-> $past(position) != '0, "list full reported for position zero")
	`PLI_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |-> !done, "result shown during reset")

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.position   (position),
	.done       (done),
	.status     (status),
	.read_value (read_value)
);

`default_nettype wire

// ----- bench/positional_list_insert_delete_tb.sv -----
`default_nettype none

module positional_list_insert_delete_tb;
	import pli_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAPACITY = 64;
	localparam int unsigned RANDOM_OPS = 1200;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] read_value;
		logic [LEN_W-1:0]         length;
	} list_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               operation;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] new_value;
	logic                     done;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] read_value;
	logic [LEN_W-1:0]         length;

	logic signed [DATA_W-1:0] list_model [CAPACITY];
	int                       list_len;
	list_result_t             expected_q [$];

	int error_count;
	int burst_left;
	int ops_sent;
	int ok_inserts;
	int ok_deletes;
	int ok_reads;
	int rejected_pos;
	int full_hits;
	int peak_len;
	int results_seen;

	positional_list_insert_delete #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.position(position),
		.new_value(new_value),
		.done(done),
		.status(status),
		.read_value(read_value),
		.length(length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic list_result_t apply_list_op(input logic [1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		list_result_t r;
		int p;
		p = int'(pos);
		r.status = ST_BADPOS;
		r.read_value = '0;
		case (op)
		OP_INSERT: begin
			if (p == 0 || p > list_len + 1) begin
				r.status = ST_BADPOS;
			end else if (list_len >= CAPACITY) begin
				r.status = ST_FULL;
				full_hits++;
			end else begin
				for (int i = list_len; i >= p; i--)
					list_model[i] = list_model[i-1];
				list_model[p-1] = val;
				list_len++;
				r.status = ST_OK;
				ok_inserts++;
			end
		end
		OP_DELETE: begin
			if (p != 0 && p <= list_len) begin
				for (int i = p - 1; i + 1 < list_len; i++)
					list_model[i] = list_model[i+1];
				list_model[list_len-1] = '0;
				list_len--;
				r.status = ST_OK;
				ok_deletes++;
			end
		end
		OP_READ: begin
			if (p != 0 && p <= list_len) begin
				r.read_value = list_model[p-1];
				r.status = ST_OK;
				ok_reads++;
			end
		end
		default: begin
		end
		endcase
		if (r.status == ST_BADPOS)
			rejected_pos++;
		if (list_len > peak_len)
			peak_len = list_len;
		r.length = LEN_W'(list_len);
		return r;
	endfunction

	task automatic idle_gap(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic issue_op(input logic [1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		if (burst_left == 0) begin
			idle_gap($urandom_range(1, 6));
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		position <= pos;
		new_value <= val;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		expected_q.push_back(apply_list_op(op, pos, val));
		ops_sent++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 11))
		0: return 32'sh7fff_ffff;
		1: return 32'sh8000_0000;
		2: return '0;
		3: return -32'sd1;
		default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_list();
		issue_op(OP_READ, 7'd1, 32'sd5);
		issue_op(OP_DELETE, 7'd1, '0);
		issue_op(OP_READ, 7'd0, '0);
		issue_op(OP_INSERT, 7'd2, 32'sd9);
		issue_op(OP_UNUSED, 7'd1, 32'sd3);
		wait_results_drained();
	endtask

	task automatic test_insert_edges();
		issue_op(OP_INSERT, 7'd1, 32'sh7fff_ffff);
		issue_op(OP_INSERT, 7'd1, 32'sh8000_0000);
		issue_op(OP_INSERT, 7'd3, '0);
		issue_op(OP_INSERT, 7'd2, -32'sd1);
		issue_op(OP_INSERT, 7'd0, 32'sd11);
		issue_op(OP_INSERT, 7'd6, 32'sd12);
		issue_op(OP_INSERT, 7'd127, 32'sd13);
		wait_results_drained();
	endtask

	task automatic test_read_delete();
		for (int p = 1; p <= 5; p++)
			issue_op(OP_READ, POS_W'(p), 32'sd77);
		issue_op(OP_READ, 7'd127, '0);
		issue_op(OP_DELETE, 7'd4, '0);
		issue_op(OP_DELETE, 7'd1, '0);
		issue_op(OP_DELETE, 7'd0, '0);
		issue_op(OP_UNUSED, 7'd1, 32'sd21);
		issue_op(OP_READ, 7'd1, '0);
		issue_op(OP_READ, 7'd2, '0);
		wait_results_drained();
	endtask

	task automatic test_full_list();
		while (list_len < CAPACITY)
			issue_op(OP_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_value());
		issue_op(OP_INSERT, POS_W'(CAPACITY + 1), 32'sd1);
		issue_op(OP_INSERT, 7'd1, 32'sd2);
		issue_op(OP_INSERT, POS_W'(CAPACITY + 2), 32'sd3);
		issue_op(OP_READ, POS_W'(CAPACITY), '0);
		issue_op(OP_READ, POS_W'(CAPACITY + 1), '0);
		issue_op(OP_DELETE, POS_W'(CAPACITY), '0);
		issue_op(OP_READ, POS_W'(CAPACITY), '0);
		issue_op(OP_INSERT, POS_W'(CAPACITY), 32'sh7fff_ffff);
		while (list_len > 0)
			issue_op(OP_DELETE, 7'd1, '0);
		wait_results_drained();
	endtask

	task automatic test_random_ops();
		bit growing;
		int pick;
		growing = 1'b1;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (list_len == CAPACITY && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (list_len == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 199) == 0)
				growing = !growing;
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				issue_op(2'($urandom_range(0, 3)), POS_W'($urandom_range(0, 127)),
					$urandom);
			end else if (pick < (growing ? 70 : 20)) begin
				case ($urandom_range(0, 3))
				0: issue_op(OP_INSERT, 7'd1, pick_value());
				1: issue_op(OP_INSERT, POS_W'(list_len + 1), pick_value());
				default: issue_op(OP_INSERT, POS_W'($urandom_range(1, list_len + 1)),
					pick_value());
				endcase
			end else if (pick < 85 && list_len > 0) begin
				issue_op(OP_DELETE, POS_W'($urandom_range(1, list_len)), $urandom);
			end else if (list_len > 0) begin
				issue_op(OP_READ, POS_W'($urandom_range(1, list_len)), $urandom);
			end else begin
				issue_op(OP_READ, POS_W'($urandom_range(0, 2)), $urandom);
			end
			if (n % 300 == 299)
				wait_results_drained();
		end
		wait_results_drained();
	endtask

	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && done) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("result with no transaction outstanding: status %0d length %0d",
					status, length);
				error_count++;
			end else begin
				exp_r = expected_q.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					error_count++;
				end
				if (read_value !== exp_r.read_value) begin
					$error("read_value: expected %0d, got %0d", exp_r.read_value,
						read_value);
					error_count++;
				end
				if (length !== exp_r.length) begin
					$error("length: expected %0d, got %0d", exp_r.length, length);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		int stalled;
		if (!arst_n || (start && !busy) || done) begin
			stalled = 0;
		end else begin
			stalled++;
			if (stalled >= STALL_LIMIT) begin
				$display("Watchdog expired with %0d results outstanding.",
					expected_q.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_INSERT;
		position = '0;
		new_value = '0;
		list_len = 0;
		for (int i = 0; i < CAPACITY; i++)
			list_model[i] = '0;
		error_count = 0;
		burst_left = 0;
		ops_sent = 0;
		ok_inserts = 0;
		ok_deletes = 0;
		ok_reads = 0;
		rejected_pos = 0;
		full_hits = 0;
		peak_len = 0;
		results_seen = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_insert_edges();
		test_read_delete();
		test_full_list();
		test_random_ops();

		repeat (4) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d results never arrived", expected_q.size());
			error_count++;
		end
		$display("Sent %0d transactions and checked %0d results; peak list length %0d.",
			ops_sent, results_seen, peak_len);
		$display("Inserts %0d, deletes %0d, reads %0d, bad positions %0d, full list %0d.",
			ok_inserts, ok_deletes, ok_reads, rejected_pos, full_hits);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+design
design/pli_pkg.sv
design/pli_cell.sv
design/positional_list_insert_delete.sv
design/pli_checker.sv
bench/positional_list_insert_delete_tb.sv
